// File: hw/rtl/epsf_pkg.sv
// Shared constants and types of the edge-preserving smoothing filter.
`timescale 1ns / 1ps
package epsf_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_WIN_DEF  = 7;

  // Sample width and signed window coordinate width (covers frames up to 4096).
  localparam int SAMPLE_W   = 16;
  localparam int COORD_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_FAST = 3'd0,
    CFG_WIN_SLOW = 3'd1,
    CFG_COLS     = 3'd2,
    CFG_ROWS     = 3'd3,
    CFG_EDGE     = 3'd4,
    CFG_SMOOTH   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/epsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module epsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/epsf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module epsf_div #(
  parameter int DW = 24,
  parameter int NW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DW-1:0]        dividend_i,
  input  logic [NW-1:0]        divisor_i,
  output epsf_pkg::div_stat_t  stat_o,
  output logic [DW-1:0]        quot_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_q;
  logic [NW-1:0]   rem_q;
  logic [NW-1:0]   dsr_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [NW:0]     shifted, diff;
  logic            ge;

  assign shifted = {rem_q, dvd_q[DW-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      // shift the next dividend bit out at the top into the remainder, quotient bit in at the bottom
      dvd_q <= {dvd_q[DW-2:0], ge};
      rem_q <= ge ? diff[NW-1:0] : shifted[NW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = dvd_q;

endmodule

// File: hw/rtl/edge_preserving_smoothing_filter_core.sv
// Top level of the edge-preserving (Kuwahara type) smoothing filter.
//
// Input channel (in_valid_i / in_stall_o): a load word writes in_sample_i at
// (in_row_i, in_col_i) of the frame store and gives no result.
// A filter word names one sample; the block tries every window that holds it,
// keeps the one of least spread (later window on ties) and returns its mean
// or median as one word on the output channel (out_valid_o / out_stall_i).
// Configuration words (cfg_valid_i / cfg_ready_o) are always taken.
// A filter word scans each of the W windows of N samples in turn, then finds
// a median by one pass of the window per result bit or a mean with the
// serial divider. The single frame store read port delivers one sample per
// cycle for these passes.
// in_stall_o is high while a filter word is in work; loads are taken in
// between while an earlier result still waits. A stalled result holds in
// the output register, and the next result waits behind it.
// Reset clears the control state and loads the default configuration; the
// frame store is not cleared and must be written before it is read.
`timescale 1ns / 1ps
module edge_preserving_smoothing_filter_core #(
  parameter int MAX_COLS = epsf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = epsf_pkg::MAX_ROWS_DEF,
  parameter int MAX_WIN  = epsf_pkg::MAX_WIN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              in_req_type_i,
  input  logic [7:0]                        in_row_i,
  input  logic [7:0]                        in_col_i,
  input  logic signed [15:0]                in_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                out_filtered_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [epsf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [epsf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int SW      = epsf_pkg::SAMPLE_W;
  localparam int CW      = epsf_pkg::COORD_W;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int LW      = $clog2(MAX_WIN + 1);
  localparam int TOP_LEN = (MAX_WIN % 2 == 0) ? MAX_WIN - 1 : MAX_WIN;
  localparam int NMAX    = MAX_WIN * MAX_WIN;
  localparam int NW      = $clog2(NMAX + 1);
  localparam int SUMW    = SW + $clog2(NMAX) + 1;
  localparam int SQW     = 2 * SW + $clog2(NMAX);
  localparam int SPW     = 2 * SUMW + NW;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_CMP    = 7'b0001000,
    ST_MEDIAN = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  function automatic logic [LW-1:0] eff_len(input logic [2:0] v);
    logic [4:0] n;
    n = {2'b00, v} + (v[0] ? 5'd0 : 5'd1);
    if (32'(n) > TOP_LEN) begin
      n = 5'(TOP_LEN);
    end
    return LW'(n);
  endfunction

  // configuration
  logic [2:0] win_fast_q, win_slow_q;
  logic [8:0] frame_cols_q, frame_rows_q;
  logic       edge_q, smooth_q;

  state_e state_q, state_d;
  logic   sweep_start, sweep_done, in_acc, last_win;

  // sweep issue and pipeline
  logic          issue_q, v1_q, v2_q, v3_q, zero1_q;
  logic [LW-1:0] k_q, kk_q;
  logic signed [SW-1:0]   x_q, x_rd;
  logic [2*SW-1:0]        sq_q;
  logic signed [2*SW-1:0] sq_full;
  logic signed [SUMW-1:0] sum_q;
  logic [SQW-1:0]         sumsq_q;
  logic [NW-1:0]          cnt_q;

  // item and window search state
  logic [7:0]    row_q, col_q;
  logic [LW-1:0] wr_q, wc_q, p_q, qi_q, best_p_q, best_c_q, p_sel, c_sel;
  logic [NW-1:0] n_q, rank_q;
  logic          have_q, div_start_q;
  logic signed [SPW-1:0]    best_q, prod_a_q, prod_b_q, spread;
  logic signed [2*SUMW-1:0] sum_sqr;
  logic signed [SUMW-1:0]   best_sum_q;
  logic [3:0]    bit_q;
  logic [SW-1:0] prefix_q, pfx_next, above, key;
  logic          match, take_one;
  logic signed [SW-1:0] res_q;
  logic          out_valid_q;
  logic signed [SW-1:0] out_data_q;

  // addressing
  logic signed [CW-1:0] rows_eff, cols_eff, rpos, cpos, rcl, ccl;
  logic                 oob;
  logic [2*CW-1:0]      rd_addr_full, ld_addr_full;
  logic                 ld_we;
  logic [SW-1:0]        rdata;

  logic [SUMW-1:0]     sum_mag, quot;
  epsf_pkg::div_stat_t div_stat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_fast_q   <= 3'd3;
      win_slow_q   <= 3'd1;
      frame_cols_q <= 9'd256;
      frame_rows_q <= 9'd256;
      edge_q       <= 1'b0;
      smooth_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (epsf_pkg::cfg_idx_e'(cfg_index_i))
        epsf_pkg::CFG_WIN_FAST: win_fast_q   <= cfg_data_i[2:0];
        epsf_pkg::CFG_WIN_SLOW: win_slow_q   <= cfg_data_i[2:0];
        epsf_pkg::CFG_COLS:     frame_cols_q <= cfg_data_i;
        epsf_pkg::CFG_ROWS:     frame_rows_q <= cfg_data_i;
        epsf_pkg::CFG_EDGE:     edge_q       <= cfg_data_i[0];
        epsf_pkg::CFG_SMOOTH:   smooth_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero acts as one, clip to the store
  always_comb begin
    if (frame_rows_q == 9'd0) begin
      rows_eff = CW'(1);
    end else if (32'(frame_rows_q) > MAX_ROWS) begin
      rows_eff = CW'(MAX_ROWS);
    end else begin
      rows_eff = CW'(frame_rows_q);
    end
    if (frame_cols_q == 9'd0) begin
      cols_eff = CW'(1);
    end else if (32'(frame_cols_q) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(frame_cols_q);
    end
  end

  // sample position of the current read, clamped into the frame
  assign p_sel = (state_q == ST_MEDIAN) ? best_p_q : p_q;
  assign c_sel = (state_q == ST_MEDIAN) ? best_c_q : qi_q;
  assign rpos  = CW'(row_q) + CW'(p_sel) + CW'(k_q) - CW'(wr_q) + CW'(1);
  assign cpos  = CW'(col_q) + CW'(c_sel) + CW'(kk_q) - CW'(wc_q) + CW'(1);

  always_comb begin
    oob = (rpos < 0) || (rpos >= rows_eff) || (cpos < 0) || (cpos >= cols_eff);
    if (rpos < 0) begin
      rcl = '0;
    end else if (rpos >= rows_eff) begin
      rcl = rows_eff - CW'(1);
    end else begin
      rcl = rpos;
    end
    if (cpos < 0) begin
      ccl = '0;
    end else if (cpos >= cols_eff) begin
      ccl = cols_eff - CW'(1);
    end else begin
      ccl = cpos;
    end
  end

  assign rd_addr_full = (2*CW)'($unsigned(rcl)) * (2*CW)'(MAX_COLS)
                      + (2*CW)'($unsigned(ccl));
  assign ld_addr_full = (2*CW)'(in_row_i) * (2*CW)'(MAX_COLS) + (2*CW)'(in_col_i);
  assign ld_we = in_acc && !in_req_type_i
              && (32'(in_row_i) < MAX_ROWS) && (32'(in_col_i) < MAX_COLS);

  epsf_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_addr_full[AW-1:0]),
    .wdata_i (in_sample_i),
    .raddr_i (rd_addr_full[AW-1:0]),
    .rdata_o (rdata)
  );

  assign x_rd    = zero1_q ? '0 : $signed(rdata);
  assign sq_full = x_q * x_q;
  assign sweep_done = !issue_q && !v1_q && !v2_q && !v3_q;
  assign last_win   = (p_q == LW'(wr_q - LW'(1))) && (qi_q == LW'(wc_q - LW'(1)));

  // median radix select on offset-binary keys
  assign key      = {~x_q[SW-1], x_q[SW-2:0]};
  assign above    = {SW{1'b1}} << (5'(bit_q) + 5'd1);
  assign match    = ((key & above) == prefix_q) && !key[bit_q];
  assign take_one = (cnt_q <= rank_q);
  assign pfx_next = prefix_q | (take_one ? (SW'(1) << bit_q) : '0);

  assign sum_sqr = sum_q * sum_q;
  assign spread  = prod_a_q - prod_b_q;
  assign sum_mag = best_sum_q[SUMW-1] ? SUMW'(-best_sum_q) : SUMW'(best_sum_q);

  always_comb begin
    state_d     = state_q;
    sweep_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_req_type_i) begin
          state_d     = ST_SCAN;
          sweep_start = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sweep_done) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_CMP;
      ST_CMP: begin
        if (!last_win) begin
          state_d     = ST_SCAN;
          sweep_start = 1'b1;
        end else if (smooth_q) begin
          state_d     = ST_MEDIAN;
          sweep_start = 1'b1;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_MEDIAN: begin
        if (sweep_done) begin
          if (bit_q == 4'd0) begin
            state_d = ST_DONE;
          end else begin
            sweep_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      k_q         <= '0;
      kk_q        <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      v1_q        <= issue_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      div_start_q <= (state_q == ST_CMP) && last_win && !smooth_q;
      if (sweep_start) begin
        issue_q <= 1'b1;
        k_q     <= '0;
        kk_q    <= '0;
      end else if (issue_q) begin
        // walk the window row by row
        if (kk_q == LW'(wc_q - LW'(1))) begin
          kk_q <= '0;
          if (k_q == LW'(wr_q - LW'(1))) begin
            issue_q <= 1'b0;
          end else begin
            k_q <= k_q + LW'(1);
          end
        end else begin
          kk_q <= kk_q + LW'(1);
        end
      end
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    zero1_q <= oob && !edge_q;
    x_q     <= x_rd;
    sq_q    <= $unsigned(sq_full);
    if (sweep_start) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (v2_q) begin
        sum_q <= sum_q + SUMW'(x_q);
        cnt_q <= cnt_q + NW'(match);
      end
      if (v3_q) begin
        sumsq_q <= sumsq_q + SQW'(sq_q);
      end
    end

    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_data_q <= res_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        row_q  <= in_row_i;
        col_q  <= in_col_i;
        wr_q   <= eff_len(win_slow_q);
        wc_q   <= eff_len(win_fast_q);
        n_q    <= NW'(32'(eff_len(win_slow_q)) * 32'(eff_len(win_fast_q)));
        p_q    <= '0;
        qi_q   <= '0;
        have_q <= 1'b0;
      end
      ST_MUL: begin
        prod_a_q <= SPW'(n_q) * SPW'(sumsq_q);
        prod_b_q <= SPW'(sum_sqr);
      end
      ST_CMP: begin
        if (!have_q || spread <= best_q) begin
          have_q     <= 1'b1;
          best_q     <= spread;
          best_p_q   <= p_q;
          best_c_q   <= qi_q;
          best_sum_q <= sum_q;
        end
        if (qi_q == LW'(wc_q - LW'(1))) begin
          qi_q <= '0;
          p_q  <= p_q + LW'(1);
        end else begin
          qi_q <= qi_q + LW'(1);
        end
        bit_q    <= 4'd15;
        prefix_q <= '0;
        rank_q   <= n_q >> 1;
      end
      ST_MEDIAN: begin
        if (sweep_done) begin
          if (take_one) rank_q <= rank_q - cnt_q;
          prefix_q <= pfx_next;
          bit_q    <= bit_q - 4'd1;
          res_q    <= {~pfx_next[SW-1], pfx_next[SW-2:0]};
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_q <= best_sum_q[SUMW-1] ? SW'(-quot) : SW'(quot);
        end
      end
      default: ;
    endcase
  end

  epsf_div #(
    .DW (SUMW),
    .NW (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (sum_mag),
    .divisor_i  (n_q),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  assign out_valid_o    = out_valid_q;
  assign out_filtered_o = out_data_q;

`ifndef SYNTHESIS
  a_filter_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_req_type_i |=> state_q == ST_SCAN)
    else $error("filter word did not start a window scan");
  a_rank_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MEDIAN |-> rank_q < n_q)
    else $error("median rank left the window");
  a_div_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == ST_DIV)
    else $error("divider running outside the divide state");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");
`endif

endmodule
